/* rtl/debounced_button_counter_7seg_core_macros.svh */
// ---------------------------------------------------------------------------
// debounced_button_counter_7seg_core assertion macros
// Shared concurrent assertion wrappers; define NO_ASSERTIONS to drop them.
// ---------------------------------------------------------------------------
`ifndef DEBOUNCED_BUTTON_COUNTER_7SEG_CORE_MACROS_SVH
`define DEBOUNCED_BUTTON_COUNTER_7SEG_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// property holds in the same cycle as its condition
`define DBC7S_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// property holds in the cycle after its condition
`define DBC7S_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define DBC7S_ASSERT_SAME(label, clk, rst, ante, cons)
`define DBC7S_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* rtl/dbc7s_pkg.sv */
// ---------------------------------------------------------------------------
// dbc7s_pkg
// Widths, divide-by-constant reciprocals, a times-ten helper and the seven-segment table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package dbc7s_pkg;

  localparam int LEVEL_W     = 8;
  localparam int EVENT_W     = 8;
  localparam int COUNT_OUT_W = 10;
  localparam int SEG_W       = 8;
  localparam int DIG_W       = 14;
  localparam int DIGIT_W     = 4;
  localparam int RECIP_W     = 16;
  localparam int PROD_W      = DIG_W + RECIP_W;

  // floor(n / d) = (n * recip) >> shift, exact for n < 2**DIG_W
  localparam logic [RECIP_W-1:0] RECIP_10    = 16'd52429;
  localparam int                 SHIFT_10    = 19;
  localparam logic [RECIP_W-1:0] RECIP_100   = 16'd5243;
  localparam int                 SHIFT_100   = 19;
  localparam logic [RECIP_W-1:0] RECIP_1000  = 16'd8389;
  localparam int                 SHIFT_1000  = 23;

  localparam int Q10_W   = 10;
  localparam int Q100_W  = 7;
  localparam int Q1000_W = 4;

  localparam logic [SEG_W-1:0] SEG_BLANK = 8'hFF;

  function automatic logic [DIG_W-1:0] times_ten(input logic [DIG_W-1:0] v);
    times_ten = {v[DIG_W-4:0], 3'b000} + {v[DIG_W-2:0], 1'b0};
  endfunction

  function automatic logic [SEG_W-1:0] seg_encode(input logic [DIGIT_W-1:0] d);
    case (d)
      4'd0:    seg_encode = 8'hC0;
      4'd1:    seg_encode = 8'hF9;
      4'd2:    seg_encode = 8'hA4;
      4'd3:    seg_encode = 8'hB0;
      4'd4:    seg_encode = 8'h99;
      4'd5:    seg_encode = 8'h92;
      4'd6:    seg_encode = 8'h82;
      4'd7:    seg_encode = 8'hF8;
      4'd8:    seg_encode = 8'h80;
      4'd9:    seg_encode = 8'h98;
      default: seg_encode = SEG_BLANK;
    endcase
  endfunction

endpackage

/* rtl/debounced_button_counter_7seg_core.sv */
// ---------------------------------------------------------------------------
// debounced_button_counter_7seg_core
// Shift-history button debounce, weighted press counter and active-low
// four-digit seven-segment encoding with leading-zero blanking.
// ---------------------------------------------------------------------------
//  channel  handshake             payload
//  in       in_valid / in_ready   button_levels
//  out      out_valid / out_ready press_events, count_value, seg_ones,
//                                 seg_tens, seg_hundreds, seg_thousands
//
//  one beat per clock sustained while out_ready is high; a beat passes, in order,
//  input register, history/count update, reciprocal multiplies and digit encode
//  the debounce history and the running count update together in the same cycle,
//  which sets the one-beat-per-clock rate
//  rst clears the histories, the count and all stage valids
//  a stalled output holds its beat; upstream stages keep filling until full
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "debounced_button_counter_7seg_core_macros.svh"

module debounced_button_counter_7seg_core #(
  parameter int BUTTON_COUNT   = 8,
  parameter int STABLE_SAMPLES = 12,
  parameter int COUNT_LIMIT    = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [dbc7s_pkg::LEVEL_W-1:0]       button_levels,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [dbc7s_pkg::EVENT_W-1:0]       press_events,
  output logic [dbc7s_pkg::COUNT_OUT_W-1:0]   count_value,
  output logic [dbc7s_pkg::SEG_W-1:0]         seg_ones,
  output logic [dbc7s_pkg::SEG_W-1:0]         seg_tens,
  output logic [dbc7s_pkg::SEG_W-1:0]         seg_hundreds,
  output logic [dbc7s_pkg::SEG_W-1:0]         seg_thousands
);

  localparam int HIST_W = STABLE_SAMPLES + 1;
  localparam int CNT_W  = $clog2(COUNT_LIMIT);
  localparam int SUM_W  = $clog2(COUNT_LIMIT + 256);
  localparam logic [HIST_W-1:0] PRESS_PATTERN = {1'b1, {STABLE_SAMPLES{1'b0}}};

  // state
  logic [HIST_W-1:0] history [BUTTON_COUNT];
  logic [HIST_W-1:0] history_next [BUTTON_COUNT];
  logic [CNT_W-1:0]  running_count;
  logic [CNT_W-1:0]  running_count_next;

  // stage registers
  logic                                s1_valid;
  logic [dbc7s_pkg::LEVEL_W-1:0]       s1_levels;
  logic                                s2_valid;
  logic [dbc7s_pkg::EVENT_W-1:0]       s2_events;
  logic [CNT_W-1:0]                    s2_count;
  logic                                s3_valid;
  logic [dbc7s_pkg::EVENT_W-1:0]       s3_events;
  logic [dbc7s_pkg::DIG_W-1:0]         s3_count;
  logic [dbc7s_pkg::Q10_W-1:0]         s3_q10;
  logic [dbc7s_pkg::Q100_W-1:0]        s3_q100;
  logic [dbc7s_pkg::Q1000_W-1:0]       s3_q1000;

  // flow control
  logic out_free, move3, s3_free, move2, s2_free, move1, accept;

  assign out_free = !out_valid || out_ready;
  assign move3    = s3_valid && out_free;
  assign s3_free  = !s3_valid || move3;
  assign move2    = s2_valid && s3_free;
  assign s2_free  = !s2_valid || move2;
  assign move1    = s1_valid && s2_free;
  assign in_ready = !s1_valid || move1;
  assign accept   = in_valid && in_ready;

  // debounce and count update
  logic [dbc7s_pkg::EVENT_W-1:0] events;
  logic [SUM_W-1:0]              sum;

  always_comb begin
    events = '0;
    for (int b = 0; b < BUTTON_COUNT; b++) begin
      history_next[b] = {history[b][HIST_W-2:0], s1_levels[b]};
      events[b]       = (history_next[b] == PRESS_PATTERN);
    end
    sum = SUM_W'(running_count) + SUM_W'(events);
    running_count_next = (sum >= SUM_W'(COUNT_LIMIT)) ? '0 : CNT_W'(sum);
  end

  // reciprocal multiplies
  logic [dbc7s_pkg::DIG_W-1:0]  s2_count_ext;
  logic [dbc7s_pkg::PROD_W-1:0] p10, p100, p1000;

  assign s2_count_ext = dbc7s_pkg::DIG_W'(s2_count);
  assign p10   = dbc7s_pkg::PROD_W'(s2_count_ext) * dbc7s_pkg::PROD_W'(dbc7s_pkg::RECIP_10);
  assign p100  = dbc7s_pkg::PROD_W'(s2_count_ext) * dbc7s_pkg::PROD_W'(dbc7s_pkg::RECIP_100);
  assign p1000 = dbc7s_pkg::PROD_W'(s2_count_ext) * dbc7s_pkg::PROD_W'(dbc7s_pkg::RECIP_1000);

  // digit extraction and encode
  logic [dbc7s_pkg::DIG_W-1:0]   r_ones, r_tens, r_hund;
  logic [dbc7s_pkg::DIGIT_W-1:0] d_ones, d_tens, d_hund, d_thou;
  logic                          show_tens, show_hund, show_thou;

  always_comb begin
    r_ones = s3_count - dbc7s_pkg::times_ten(dbc7s_pkg::DIG_W'(s3_q10));
    r_tens = dbc7s_pkg::DIG_W'(s3_q10) - dbc7s_pkg::times_ten(dbc7s_pkg::DIG_W'(s3_q100));
    r_hund = dbc7s_pkg::DIG_W'(s3_q100) - dbc7s_pkg::times_ten(dbc7s_pkg::DIG_W'(s3_q1000));
    d_ones = r_ones[dbc7s_pkg::DIGIT_W-1:0];
    d_tens = r_tens[dbc7s_pkg::DIGIT_W-1:0];
    d_hund = r_hund[dbc7s_pkg::DIGIT_W-1:0];
    d_thou = s3_q1000;
    show_thou = (d_thou != '0);
    show_hund = (d_hund != '0) || show_thou;
    show_tens = (d_tens != '0) || show_hund;
  end

  // state and stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < BUTTON_COUNT; b++) begin
        history[b] <= '0;
      end
      running_count <= '0;
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      s3_valid      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s2_free) begin
        s2_valid <= s1_valid;
      end
      if (s3_free) begin
        s3_valid <= s2_valid;
      end
      if (out_free) begin
        out_valid <= s3_valid;
      end
      if (move1) begin
        for (int b = 0; b < BUTTON_COUNT; b++) begin
          history[b] <= history_next[b];
        end
        running_count <= running_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_levels <= button_levels;
    end
    if (move1) begin
      s2_events <= events;
      s2_count  <= running_count_next;
    end
    if (move2) begin
      s3_events <= s2_events;
      s3_count  <= s2_count_ext;
      s3_q10    <= p10[dbc7s_pkg::SHIFT_10 +: dbc7s_pkg::Q10_W];
      s3_q100   <= p100[dbc7s_pkg::SHIFT_100 +: dbc7s_pkg::Q100_W];
      s3_q1000  <= p1000[dbc7s_pkg::SHIFT_1000 +: dbc7s_pkg::Q1000_W];
    end
    if (move3) begin
      press_events  <= s3_events;
      count_value   <= s3_count[dbc7s_pkg::COUNT_OUT_W-1:0];
      seg_ones      <= dbc7s_pkg::seg_encode(d_ones);
      seg_tens      <= show_tens ? dbc7s_pkg::seg_encode(d_tens) : dbc7s_pkg::SEG_BLANK;
      seg_hundreds  <= show_hund ? dbc7s_pkg::seg_encode(d_hund) : dbc7s_pkg::SEG_BLANK;
      seg_thousands <= show_thou ? dbc7s_pkg::seg_encode(d_thou) : dbc7s_pkg::SEG_BLANK;
    end
  end

  // assertions
  `DBC7S_ASSERT_NEXT(a_count_holds, clk, rst, !move1, $stable(running_count))
  `DBC7S_ASSERT_SAME(a_count_in_range, clk, rst, s3_valid,
                     s3_count < dbc7s_pkg::DIG_W'(COUNT_LIMIT))
  `DBC7S_ASSERT_SAME(a_ones_shown, clk, rst, out_valid, seg_ones != dbc7s_pkg::SEG_BLANK)

endmodule

/* test/debounced_button_counter_7seg_core_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// debounced_button_counter_7seg_core_tb
// Drives scan ticks of eight active-low buttons through the valid/ready input,
// predicts the debounce events, the weighted running count with its clear at
// the limit and the blanked seven-segment digits, and compares every output
// beat field by field. Bounce-shaped button traffic with random idling on both
// sides, a long idle-free stretch and a long output hold-off are covered.
// ---------------------------------------------------------------------------

module debounced_button_counter_7seg_core_tb;

  localparam int BUTTONS        = 8;
  localparam int STABLE         = 12;
  localparam int LIMIT          = 1024;
  localparam int HIST_W         = STABLE + 1;
  localparam int HOLDOFF_CYCLES = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 20;

  localparam logic [HIST_W-1:0] PRESS_PATTERN = {1'b1, {STABLE{1'b0}}};
  localparam logic [dbc7s_pkg::SEG_W-1:0] DIGIT_SEGS [10] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h98
  };

  typedef struct packed {
    logic [dbc7s_pkg::EVENT_W-1:0]     events;
    logic [dbc7s_pkg::COUNT_OUT_W-1:0] count;
    logic [dbc7s_pkg::SEG_W-1:0]       ones;
    logic [dbc7s_pkg::SEG_W-1:0]       tens;
    logic [dbc7s_pkg::SEG_W-1:0]       hundreds;
    logic [dbc7s_pkg::SEG_W-1:0]       thousands;
  } readout_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic [dbc7s_pkg::LEVEL_W-1:0]     button_levels = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic [dbc7s_pkg::EVENT_W-1:0]     press_events;
  logic [dbc7s_pkg::COUNT_OUT_W-1:0] count_value;
  logic [dbc7s_pkg::SEG_W-1:0]       seg_ones;
  logic [dbc7s_pkg::SEG_W-1:0]       seg_tens;
  logic [dbc7s_pkg::SEG_W-1:0]       seg_hundreds;
  logic [dbc7s_pkg::SEG_W-1:0]       seg_thousands;

  // predictor state
  logic [HIST_W-1:0] btn_history [BUTTONS];
  int                tally;
  readout_t          expected_readouts [$];

  // bounce generator state
  logic [BUTTONS-1:0] gen_level;
  int                 gen_hold [BUTTONS];

  // run control and statistics
  bit tx_idle_on = 1'b0;
  bit rx_idle_on = 1'b0;
  int hold_token = 0;
  int hold_seen  = 0;
  int hold_left  = 0;
  int idle_cycles = 0;
  int failures = 0;
  int ticks_sent = 0;
  int presses_seen = 0;
  int count_clears = 0;
  int peak_count = 0;

  debounced_button_counter_7seg_core u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .button_levels (button_levels),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .press_events  (press_events),
    .count_value   (count_value),
    .seg_ones      (seg_ones),
    .seg_tens      (seg_tens),
    .seg_hundreds  (seg_hundreds),
    .seg_thousands (seg_thousands)
  );

  always #5 clk = ~clk;

  // debounce history shift, weighted count and digit encode for one tick
  function automatic readout_t score_tick(input logic [dbc7s_pkg::LEVEL_W-1:0] lv);
    readout_t r;
    int sum;
    int d1, d10, d100, d1000;
    sum = tally;
    r.events = '0;
    for (int b = 0; b < BUTTONS; b++) begin
      btn_history[b] = {btn_history[b][HIST_W-2:0], lv[b]};
      if (btn_history[b] == PRESS_PATTERN) begin
        r.events[b] = 1'b1;
        sum += 1 << b;
      end
    end
    if (sum >= LIMIT) begin
      sum = 0;
      count_clears++;
    end
    tally = sum;
    presses_seen += $countones(r.events);
    if (sum > peak_count) peak_count = sum;
    d1    = sum % 10;
    d10   = (sum % 100) / 10;
    d100  = (sum % 1000) / 100;
    d1000 = (sum % 10000) / 1000;
    r.count     = sum[dbc7s_pkg::COUNT_OUT_W-1:0];
    r.ones      = DIGIT_SEGS[d1];
    r.tens      = (d10 != 0 || d100 != 0 || d1000 != 0) ? DIGIT_SEGS[d10]
                                                        : dbc7s_pkg::SEG_BLANK;
    r.hundreds  = (d100 != 0 || d1000 != 0) ? DIGIT_SEGS[d100] : dbc7s_pkg::SEG_BLANK;
    r.thousands = (d1000 != 0) ? DIGIT_SEGS[d1000] : dbc7s_pkg::SEG_BLANK;
    return r;
  endfunction

  // per-button level runs: short bounces, near misses and full holds
  function automatic logic [dbc7s_pkg::LEVEL_W-1:0] next_bounce_levels();
    int r;
    for (int b = 0; b < BUTTONS; b++) begin
      if (gen_hold[b] == 0) begin
        gen_level[b] = ~gen_level[b];
        r = $urandom_range(99);
        if (r < 20)      gen_hold[b] = $urandom_range(3, 1);
        else if (r < 30) gen_hold[b] = STABLE - 1;
        else if (r < 40) gen_hold[b] = STABLE;
        else             gen_hold[b] = $urandom_range(STABLE + 6, STABLE);
      end
      gen_hold[b]--;
    end
    return gen_level;
  endfunction

  task automatic send_tick(input logic [dbc7s_pkg::LEVEL_W-1:0] lv);
    while (tx_idle_on && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    button_levels <= lv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_readouts.push_back(score_tick(lv));
    ticks_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_readouts.size() != 0) @(posedge clk);
  endtask

  task automatic test_held_from_reset();
    repeat (4) send_tick(8'h00);
  endtask

  task automatic test_full_press();
    send_tick(8'hFF);
    repeat (STABLE + 1) send_tick(8'h00);
    send_tick(8'hFF);
  endtask

  task automatic test_bounce_random(input int n);
    tx_idle_on = 1'b1;
    rx_idle_on <= 1'b1;
    repeat (n) begin
      if ($urandom_range(99) < 10) send_tick(dbc7s_pkg::LEVEL_W'($urandom_range(255)));
      else send_tick(next_bounce_levels());
    end
  endtask

  task automatic test_steady_stream(input int n);
    tx_idle_on = 1'b0;
    rx_idle_on <= 1'b0;
    repeat (n) send_tick(next_bounce_levels());
  endtask

  task automatic test_output_holdoff(input int n);
    tx_idle_on = 1'b0;
    hold_token <= hold_token + 1;
    repeat (n) send_tick(next_bounce_levels());
    wait_drained();
  endtask

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      failures++;
    end
  endtask

  // output side ready pattern, with an occasional long hold-off
  always @(posedge clk) begin
    if (hold_seen != hold_token) begin
      hold_seen <= hold_token;
      hold_left <= HOLDOFF_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(rx_idle_on && $urandom_range(99) < 18);
    end
  end

  always @(posedge clk) begin
    readout_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (expected_readouts.size() == 0) begin
        $error("output beat with nothing expected");
        failures++;
      end else begin
        exp_r = expected_readouts.pop_front();
        check_field("press_events", exp_r.events, press_events);
        check_field("count_value", exp_r.count, count_value);
        check_field("seg_ones", exp_r.ones, seg_ones);
        check_field("seg_tens", exp_r.tens, seg_tens);
        check_field("seg_hundreds", exp_r.hundreds, seg_hundreds);
        check_field("seg_thousands", exp_r.thousands, seg_thousands);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    for (int b = 0; b < BUTTONS; b++) begin
      btn_history[b] = '0;
      gen_hold[b]    = $urandom_range(STABLE + 4, 1);
    end
    gen_level = '1;
    tally     = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_held_from_reset();
    test_full_press();
    test_bounce_random(650);
    test_steady_stream(140);
    test_output_holdoff(40);
    test_bounce_random(20);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_readouts.size() != 0) begin
      $error("%0d expected beats never arrived", expected_readouts.size());
      failures++;
    end
    $display("run covered %0d scan ticks, %0d recognized presses, %0d count clears",
             ticks_sent, presses_seen, count_clears);
    $display("peak count %0d, with random idling, an idle-free stretch and a long hold-off",
             peak_count);
    if (failures == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule
